[rtl/lfsc_pkg.sv]
package lfsc_pkg;

    localparam int SENSOR_W  = 10;
    localparam int ECHO_W    = 15;
    localparam int CMD_W     = 8;
    localparam int SPEED_W   = 8;
    localparam int HOLD_W    = 12;
    localparam int MODE_W    = 2;
    localparam int DEV_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;
    localparam int NUM_LANES = 5;
    localparam int DIST_W    = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_LVL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_LVL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROXIMITY_CM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST_CM    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CREEP_SPEED    = 3'd5;

    localparam logic [SENSOR_W-1:0] RST_LINE_THRESHOLD = 10'd750;
    localparam logic [SPEED_W-1:0]  RST_CRUISE_LVL     = 8'd130;
    localparam logic [SPEED_W-1:0]  RST_PIVOT_LVL      = 8'd210;
    localparam logic [SENSOR_W-1:0] RST_PROXIMITY_CM   = 10'd30;
    localparam logic [SENSOR_W-1:0] RST_MIN_DIST_CM    = 10'd10;
    localparam logic [SPEED_W-1:0]  RST_CREEP_SPEED    = 8'd130;

    // modes
    localparam logic [MODE_W-1:0] MODE_FOLLOW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OBSTACLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP     = 2'd2;

    // last deviation side
    localparam logic [DEV_W-1:0] DEV_RIGHT = 2'd0;
    localparam logic [DEV_W-1:0] DEV_LEFT  = 2'd1;
    localparam logic [DEV_W-1:0] DEV_NONE  = 2'd2;

    // commands
    localparam logic [CMD_W-1:0] CMD_NONE    = 8'd0;
    localparam logic [CMD_W-1:0] CMD_FOLLOW  = 8'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 8'd2;
    localparam logic [CMD_W-1:0] CMD_FORWARD = 8'd3;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 8'd4;

    localparam logic [HOLD_W-1:0] HOLD_FOLLOW     = 12'd20;
    localparam logic [HOLD_W-1:0] HOLD_BYPASS     = 12'd2000;
    localparam logic [HOLD_W-1:0] HOLD_BYPASS_END = 12'd3000;
    localparam logic [HOLD_W-1:0] HOLD_STOP       = 12'd1000;

    localparam logic [DIST_W-1:0] ECHO_US_PER_CM = 16'd50;
    localparam logic [SENSOR_W-1:0] NO_ECHO_CM   = 10'd100;

    localparam logic [SPEED_W-1:0] OFS_CENTER    = 8'd30;
    localparam logic [SPEED_W-1:0] OFS_SLOW_SIDE = 8'd80;
    localparam logic [SPEED_W-1:0] OFS_LEFT_FAST = 8'd40;
    localparam logic [SPEED_W-1:0] OFS_RIGHT_FAST = 8'd20;
    localparam logic [SPEED_W-1:0] OFS_PIVOT_IN  = 8'd5;
    localparam logic [SPEED_W-1:0] OFS_PIVOT_OUT = 8'd10;

    localparam int LANE_LO = 0;
    localparam int LANE_LI = 1;
    localparam int LANE_MI = 2;
    localparam int LANE_RI = 3;
    localparam int LANE_RO = 4;

    typedef struct packed {
        logic [NUM_LANES-1:0] on_line;
        logic                 obstacle;
        logic [CMD_W-1:0]     cmd;
    } pass_t;

    typedef struct packed {
        logic               left_forward;
        logic [SPEED_W-1:0] left_speed;
        logic               right_forward;
        logic [SPEED_W-1:0] right_speed;
        logic [HOLD_W-1:0]  hold_ms;
        logic [MODE_W-1:0]  mode_now;
        logic               last_of_run;
    } result_t;

    function automatic logic [SPEED_W-1:0] sat_sub(input logic [SPEED_W-1:0] v,
                                                   input logic [SPEED_W-1:0] k);
        logic [SPEED_W-1:0] r;
        r = (v < k) ? '0 : v - k;
        return r;
    endfunction

    function automatic logic [SPEED_W-1:0] sat_add(input logic [SPEED_W-1:0] v,
                                                   input logic [SPEED_W-1:0] k);
        logic [SPEED_W:0] s;
        s = {1'b0, v} + {1'b0, k};
        return s[SPEED_W] ? '1 : s[SPEED_W-1:0];
    endfunction

endpackage

[rtl/line_follower_steering_controller.sv]
// Channel   Direction  Handshake           Beat contents
// s_*       in         s_valid / s_ready   five sensor readings, echo width, command
// m_*       out        m_valid / m_ready   wheel directions and levels, hold, mode, last
// cfg_*     in         cfg_we              register index and write data
//
// A pass is registered in the sensor lanes, then the merge sequencer emits its
// results: 1 per pass in follow and stop mode, 4 for an obstacle bypass, so one
// pass per cycle sustained outside of bypasses while m_ready stays high.
// Reset (aresetn low at a clock edge) clears control state and restores the
// register defaults. A stall on m_ready holds the result; the lanes take one
// further beat while a result waits, then s_ready drops until m_ready returns.
module line_follower_steering_controller (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [lfsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfsc_pkg::CFG_DAT_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lfsc_pkg::SENSOR_W-1:0]  s_sensor_left_outer,
    input  logic [lfsc_pkg::SENSOR_W-1:0]  s_sensor_left_inner,
    input  logic [lfsc_pkg::SENSOR_W-1:0]  s_sensor_middle,
    input  logic [lfsc_pkg::SENSOR_W-1:0]  s_sensor_right_inner,
    input  logic [lfsc_pkg::SENSOR_W-1:0]  s_sensor_right_outer,
    input  logic [lfsc_pkg::ECHO_W-1:0]    s_echo_low_us,
    input  logic [lfsc_pkg::CMD_W-1:0]     s_command_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_left_forward,
    output logic [lfsc_pkg::SPEED_W-1:0]   m_left_speed,
    output logic                           m_right_forward,
    output logic [lfsc_pkg::SPEED_W-1:0]   m_right_speed,
    output logic [lfsc_pkg::HOLD_W-1:0]    m_hold_ms,
    output logic [lfsc_pkg::MODE_W-1:0]    m_mode_now,
    output logic                           m_last_of_run
);
    import lfsc_pkg::*;

    logic [SENSOR_W-1:0] line_threshold_reg;
    logic [SPEED_W-1:0]  cruise_lvl_reg;
    logic [SPEED_W-1:0]  pivot_lvl_reg;
    logic [SENSOR_W-1:0] proximity_reg;
    logic [SENSOR_W-1:0] min_dist_reg;
    logic [SPEED_W-1:0]  creep_speed_reg;

    logic                pass_valid_reg, pass_valid_next;
    logic                obstacle_reg, obstacle_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic                pass_done;
    logic                in_load;
    logic                obstacle;
    logic [DIST_W-1:0]   echo_ext;
    logic [DIST_W-1:0]   near_bound;
    logic [DIST_W-1:0]   far_bound;
    logic [NUM_LANES-1:0] on_line;
    logic [SENSOR_W-1:0] readings [NUM_LANES];
    pass_t               pass;
    result_t             result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_threshold_reg <= RST_LINE_THRESHOLD;
            cruise_lvl_reg     <= RST_CRUISE_LVL;
            pivot_lvl_reg      <= RST_PIVOT_LVL;
            proximity_reg      <= RST_PROXIMITY_CM;
            min_dist_reg       <= RST_MIN_DIST_CM;
            creep_speed_reg    <= RST_CREEP_SPEED;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LINE_THRESHOLD: line_threshold_reg <= cfg_wdata;
                REG_CRUISE_LVL:     cruise_lvl_reg     <= cfg_wdata[SPEED_W-1:0];
                REG_PIVOT_LVL:      pivot_lvl_reg      <= cfg_wdata[SPEED_W-1:0];
                REG_PROXIMITY_CM:   proximity_reg      <= cfg_wdata;
                REG_MIN_DIST_CM:    min_dist_reg       <= cfg_wdata;
                REG_CREEP_SPEED:    creep_speed_reg    <= cfg_wdata[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !pass_valid_reg || pass_done;
    assign in_load = s_valid && s_ready;

    // dist = echo / 50, compared without dividing:
    // dist > min  <=> echo >= 50 * (min + 1);  dist < prox <=> echo < 50 * prox
    assign echo_ext   = {{(DIST_W-ECHO_W){1'b0}}, s_echo_low_us};
    assign far_bound  = ECHO_US_PER_CM * ({{(DIST_W-SENSOR_W){1'b0}}, min_dist_reg}
                                          + DIST_W'(1));
    assign near_bound = ECHO_US_PER_CM * {{(DIST_W-SENSOR_W){1'b0}}, proximity_reg};

    always_comb begin
        if (s_echo_low_us == '0) begin
            obstacle = (NO_ECHO_CM > min_dist_reg) && (NO_ECHO_CM < proximity_reg);
        end else begin
            obstacle = (echo_ext >= far_bound) && (echo_ext < near_bound);
        end
    end

    assign readings[LANE_LO] = s_sensor_left_outer;
    assign readings[LANE_LI] = s_sensor_left_inner;
    assign readings[LANE_MI] = s_sensor_middle;
    assign readings[LANE_RI] = s_sensor_right_inner;
    assign readings[LANE_RO] = s_sensor_right_outer;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        lfsc_lane u_lane (
            .aclk      (aclk),
            .load      (in_load),
            .reading   (readings[g]),
            .threshold (line_threshold_reg),
            .on_line   (on_line[g])
        );
    end

    assign pass_valid_next = in_load ? 1'b1 : (pass_done ? 1'b0 : pass_valid_reg);
    assign obstacle_next   = in_load ? obstacle : obstacle_reg;
    assign cmd_next        = in_load ? s_command_in : cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_valid_reg <= 1'b0;
        end else begin
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        obstacle_reg <= obstacle_next;
        cmd_reg      <= cmd_next;
    end

    assign pass.on_line  = on_line;
    assign pass.obstacle = obstacle_reg;
    assign pass.cmd      = cmd_reg;

    lfsc_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pass_valid  (pass_valid_reg),
        .pass        (pass),
        .pass_done   (pass_done),
        .cruise_lvl  (cruise_lvl_reg),
        .pivot_lvl   (pivot_lvl_reg),
        .creep_speed (creep_speed_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .result      (result)
    );

    assign m_left_forward  = result.left_forward;
    assign m_left_speed    = result.left_speed;
    assign m_right_forward = result.right_forward;
    assign m_right_speed   = result.right_speed;
    assign m_hold_ms       = result.hold_ms;
    assign m_mode_now      = result.mode_now;
    assign m_last_of_run   = result.last_of_run;

endmodule

[rtl/lfsc_lane.sv]
module lfsc_lane (
    input  logic                          aclk,
    input  logic                          load,
    input  logic [lfsc_pkg::SENSOR_W-1:0] reading,
    input  logic [lfsc_pkg::SENSOR_W-1:0] threshold,
    output logic                          on_line
);
    import lfsc_pkg::*;

    logic on_line_reg;
    logic on_line_next;

    assign on_line_next = load ? (reading > threshold) : on_line_reg;

    always_ff @(posedge aclk) begin
        on_line_reg <= on_line_next;
    end

    assign on_line = on_line_reg;

endmodule

[rtl/lfsc_merge.sv]
module lfsc_merge (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         pass_valid,
    input  lfsc_pkg::pass_t              pass,
    output logic                         pass_done,
    input  logic [lfsc_pkg::SPEED_W-1:0] cruise_lvl,
    input  logic [lfsc_pkg::SPEED_W-1:0] pivot_lvl,
    input  logic [lfsc_pkg::SPEED_W-1:0] creep_speed,
    output logic                         m_valid,
    input  logic                         m_ready,
    output lfsc_pkg::result_t            result
);
    import lfsc_pkg::*;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [DEV_W-1:0]  dev_reg, dev_next;
    logic              rev_reg, rev_next;
    logic [CMD_W-1:0]  cur_cmd_reg, cur_cmd_next;
    logic [CMD_W-1:0]  app_cmd_reg, app_cmd_next;
    logic              ldir_reg, ldir_next;
    logic              rdir_reg, rdir_next;
    logic [1:0]        step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    result_t           result_reg, result_next;

    logic              out_load;
    logic              upd_dir;
    logic              ld_req, rd_req;
    logic [SPEED_W-1:0] ls, rs;
    logic [HOLD_W-1:0] hold;
    logic              last;
    logic [MODE_W-1:0] mode_act;
    logic [DEV_W-1:0]  dev_act;
    logic [CMD_W-1:0]  cmd_eff;
    logic              sl, sm, sr, slo, sro;

    assign out_load  = pass_valid && (!m_valid_reg || m_ready);
    assign pass_done = out_load && last;

    assign slo = pass.on_line[LANE_LO];
    assign sl  = pass.on_line[LANE_LI];
    assign sm  = pass.on_line[LANE_MI];
    assign sr  = pass.on_line[LANE_RI];
    assign sro = pass.on_line[LANE_RO];

    // one result of the pass per cycle while the output is not stalled
    always_comb begin
        upd_dir  = 1'b0;
        ld_req   = 1'b1;
        rd_req   = 1'b1;
        ls       = '0;
        rs       = '0;
        hold     = HOLD_FOLLOW;
        last     = 1'b1;
        mode_act = mode_reg;
        dev_act  = dev_reg;
        case (mode_reg)
            MODE_FOLLOW: begin
                if (pass.obstacle) begin
                    mode_act = MODE_OBSTACLE;
                end else begin
                    upd_dir = 1'b1;
                    if ((sl && sm) || (sm && sr)) begin
                        ls = sat_sub(cruise_lvl, OFS_CENTER);
                        rs = sat_sub(cruise_lvl, OFS_CENTER);
                    end else if (sl) begin
                        ls      = sat_sub(cruise_lvl, OFS_SLOW_SIDE);
                        rs      = sat_add(cruise_lvl, OFS_LEFT_FAST);
                        dev_act = DEV_NONE;
                    end else if (sr) begin
                        ls      = sat_add(cruise_lvl, OFS_RIGHT_FAST);
                        rs      = sat_sub(cruise_lvl, OFS_SLOW_SIDE);
                        dev_act = DEV_NONE;
                    end else if (slo || dev_reg == DEV_LEFT) begin
                        ld_req  = 1'b0;
                        ls      = pivot_lvl;
                        rs      = pivot_lvl;
                        dev_act = DEV_LEFT;
                    end else if (sro || dev_reg == DEV_RIGHT) begin
                        rd_req  = 1'b0;
                        ls      = pivot_lvl;
                        rs      = pivot_lvl;
                        dev_act = DEV_RIGHT;
                    end else begin
                        ls = creep_speed;
                        rs = creep_speed;
                    end
                end
            end
            MODE_OBSTACLE: begin
                hold    = HOLD_BYPASS;
                last    = 1'b0;
                dev_act = DEV_NONE;
                case (step_reg)
                    2'd0: begin
                    end
                    2'd1: begin
                        upd_dir = 1'b1;
                        ld_req  = 1'b0;
                        ls      = sat_sub(pivot_lvl, OFS_PIVOT_IN);
                        rs      = sat_sub(pivot_lvl, OFS_PIVOT_IN);
                    end
                    2'd2: begin
                        upd_dir = 1'b1;
                        ls      = creep_speed;
                        rs      = creep_speed;
                    end
                    default: begin
                        upd_dir  = 1'b1;
                        rd_req   = 1'b0;
                        ls       = sat_add(pivot_lvl, OFS_PIVOT_OUT);
                        rs       = sat_add(pivot_lvl, OFS_PIVOT_OUT);
                        hold     = HOLD_BYPASS_END;
                        last     = 1'b1;
                        mode_act = MODE_FOLLOW;
                    end
                endcase
            end
            default: begin
                hold = HOLD_STOP;
            end
        endcase
    end

    assign ldir_next = (out_load && upd_dir) ? (ld_req ^ rev_reg) : ldir_reg;
    assign rdir_next = (out_load && upd_dir) ? (rd_req ^ rev_reg) : rdir_reg;

    // apply the command after the mode action
    assign cmd_eff = (pass.cmd != CMD_NONE) ? pass.cmd : cur_cmd_reg;

    always_comb begin
        mode_next    = mode_reg;
        dev_next     = dev_reg;
        rev_next     = rev_reg;
        cur_cmd_next = cur_cmd_reg;
        app_cmd_next = app_cmd_reg;
        if (pass_done) begin
            mode_next    = mode_act;
            dev_next     = dev_act;
            cur_cmd_next = cmd_eff;
            app_cmd_next = cmd_eff;
            if (cmd_eff != app_cmd_reg) begin
                case (cmd_eff)
                    CMD_FOLLOW:  mode_next = MODE_FOLLOW;
                    CMD_STOP:    mode_next = MODE_STOP;
                    CMD_FORWARD: rev_next  = 1'b0;
                    CMD_REVERSE: rev_next  = 1'b1;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        step_next = step_reg;
        if (out_load) begin
            step_next = last ? 2'd0 : step_reg + 2'd1;
        end
    end

    always_comb begin
        result_next = result_reg;
        if (out_load) begin
            result_next.left_forward  = ldir_next;
            result_next.left_speed    = ls;
            result_next.right_forward = rdir_next;
            result_next.right_speed   = rs;
            result_next.hold_ms       = hold;
            result_next.mode_now      = mode_reg;
            result_next.last_of_run   = last;
        end
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_FOLLOW;
            dev_reg     <= DEV_NONE;
            rev_reg     <= 1'b0;
            cur_cmd_reg <= CMD_FOLLOW;
            app_cmd_reg <= CMD_FOLLOW;
            ldir_reg    <= 1'b0;
            rdir_reg    <= 1'b0;
            step_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            dev_reg     <= dev_next;
            rev_reg     <= rev_next;
            cur_cmd_reg <= cur_cmd_next;
            app_cmd_reg <= app_cmd_next;
            ldir_reg    <= ldir_next;
            rdir_reg    <= rdir_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

    a_step_needs_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg != 2'd0 |-> pass_valid && mode_reg == MODE_OBSTACLE)
        else $error("bypass step advanced without a held obstacle pass");

    a_bypass_end_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.last_of_run && result_reg.mode_now == MODE_OBSTACLE
        |-> result_reg.hold_ms == HOLD_BYPASS_END)
        else $error("bypass ended on the wrong leg");

    a_done_resets_step: assert property (@(posedge aclk) disable iff (!aresetn)
        pass_done |=> step_reg == 2'd0)
        else $error("step counter not cleared after a pass");

    a_applied_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        pass_done |=> app_cmd_reg == cur_cmd_reg)
        else $error("command not applied at the end of a pass");

endmodule

[sim/line_follower_steering_controller_test.sv]
`timescale 1ns / 100ps

module line_follower_steering_controller_test;

    import lfsc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [SENSOR_W-1:0] LVL_ON  = 10'd900;
    localparam logic [SENSOR_W-1:0] LVL_OFF = 10'd100;

    typedef struct packed {
        logic [SENSOR_W-1:0] lo;
        logic [SENSOR_W-1:0] li;
        logic [SENSOR_W-1:0] mi;
        logic [SENSOR_W-1:0] ri;
        logic [SENSOR_W-1:0] ro;
        logic [ECHO_W-1:0]   echo;
        logic [CMD_W-1:0]    cmd;
    } sensor_pass_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [SENSOR_W-1:0]  s_sensor_left_outer = '0;
    logic [SENSOR_W-1:0]  s_sensor_left_inner = '0;
    logic [SENSOR_W-1:0]  s_sensor_middle = '0;
    logic [SENSOR_W-1:0]  s_sensor_right_inner = '0;
    logic [SENSOR_W-1:0]  s_sensor_right_outer = '0;
    logic [ECHO_W-1:0]    s_echo_low_us = '0;
    logic [CMD_W-1:0]     s_command_in = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_left_forward;
    logic [SPEED_W-1:0]   m_left_speed;
    logic                 m_right_forward;
    logic [SPEED_W-1:0]   m_right_speed;
    logic [HOLD_W-1:0]    m_hold_ms;
    logic [MODE_W-1:0]    m_mode_now;
    logic                 m_last_of_run;

    line_follower_steering_controller i_dut (.*);

    always #10 aclk = ~aclk;

    // controller state as the steering logic should see it
    logic [SENSOR_W-1:0] line_thresh;
    logic [SPEED_W-1:0]  base_lvl, turn_lvl, creep_lvl;
    logic [SENSOR_W-1:0] prox_cm, min_cm;
    logic [MODE_W-1:0]   robot_mode;
    logic [DEV_W-1:0]    last_dev;
    logic                reverse_on;
    logic [CMD_W-1:0]    cur_cmd, app_cmd;
    logic                left_dir, right_dir;

    sensor_pass_t pending_passes[$];
    result_t      expected_drives[$];
    sensor_pass_t cur_pass;
    result_t      seen_drive, want_drive;

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  passes_accepted = 0;
    int  beats_checked = 0;
    int  obstacle_stops = 0;
    int  bypass_runs = 0;
    int  stop_passes = 0;
    int  settings_used = 1;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SPEED_W-1:0] clamp8(input int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return '1;
        return v[SPEED_W-1:0];
    endfunction

    function automatic result_t drive_beat(input logic [SPEED_W-1:0] ls,
                                           input logic [SPEED_W-1:0] rs,
                                           input logic [HOLD_W-1:0] hold,
                                           input logic [MODE_W-1:0] m);
        result_t r;
        r.left_forward  = left_dir;
        r.left_speed    = ls;
        r.right_forward = right_dir;
        r.right_speed   = rs;
        r.hold_ms       = hold;
        r.mode_now      = m;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // latch the pin levels (inverted in reverse) and build the beat
    function automatic result_t steer_beat(input logic want_l, input logic [SPEED_W-1:0] ls,
                                           input logic want_r, input logic [SPEED_W-1:0] rs,
                                           input logic [HOLD_W-1:0] hold,
                                           input logic [MODE_W-1:0] m);
        left_dir  = want_l ^ reverse_on;
        right_dir = want_r ^ reverse_on;
        return drive_beat(ls, rs, hold, m);
    endfunction

    task automatic predict_drives(input sensor_pass_t p);
        result_t          beats [4];
        int               n;
        int               b, t, range_cm;
        logic             sl, sm, sr;
        logic [MODE_W-1:0] m;
        n = 0;
        b = base_lvl;
        t = turn_lvl;
        m = robot_mode;
        if (m == MODE_FOLLOW) begin
            range_cm = (p.echo == 0) ? int'(NO_ECHO_CM) : p.echo / 50;
            if (range_cm > min_cm && range_cm < prox_cm) begin
                beats[0] = drive_beat('0, '0, HOLD_FOLLOW, m);
                n = 1;
                robot_mode = MODE_OBSTACLE;
                obstacle_stops++;
            end else begin
                sl = p.li > line_thresh;
                sm = p.mi > line_thresh;
                sr = p.ri > line_thresh;
                n = 1;
                if ((sl && sm) || (sm && sr)) begin
                    beats[0] = steer_beat(1'b1, clamp8(b - OFS_CENTER), 1'b1,
                                          clamp8(b - OFS_CENTER), HOLD_FOLLOW, m);
                end else if (sl) begin
                    beats[0] = steer_beat(1'b1, clamp8(b - OFS_SLOW_SIDE), 1'b1,
                                          clamp8(b + OFS_LEFT_FAST), HOLD_FOLLOW, m);
                    last_dev = DEV_NONE;
                end else if (sr) begin
                    beats[0] = steer_beat(1'b1, clamp8(b + OFS_RIGHT_FAST), 1'b1,
                                          clamp8(b - OFS_SLOW_SIDE), HOLD_FOLLOW, m);
                    last_dev = DEV_NONE;
                end else if (p.lo > line_thresh || last_dev == DEV_LEFT) begin
                    beats[0] = steer_beat(1'b0, turn_lvl, 1'b1, turn_lvl, HOLD_FOLLOW, m);
                    last_dev = DEV_LEFT;
                end else if (p.ro > line_thresh || last_dev == DEV_RIGHT) begin
                    beats[0] = steer_beat(1'b1, turn_lvl, 1'b0, turn_lvl, HOLD_FOLLOW, m);
                    last_dev = DEV_RIGHT;
                end else begin
                    beats[0] = steer_beat(1'b1, creep_lvl, 1'b1, creep_lvl, HOLD_FOLLOW, m);
                end
            end
        end else if (m == MODE_OBSTACLE) begin
            // timed bypass: halt, pivot out, straight leg, pivot back
            last_dev = DEV_NONE;
            beats[0] = drive_beat('0, '0, HOLD_BYPASS, m);
            beats[1] = steer_beat(1'b0, clamp8(t - OFS_PIVOT_IN), 1'b1,
                                  clamp8(t - OFS_PIVOT_IN), HOLD_BYPASS, m);
            beats[2] = steer_beat(1'b1, creep_lvl, 1'b1, creep_lvl, HOLD_BYPASS, m);
            beats[3] = steer_beat(1'b1, clamp8(t + OFS_PIVOT_OUT), 1'b0,
                                  clamp8(t + OFS_PIVOT_OUT), HOLD_BYPASS_END, m);
            n = 4;
            robot_mode = MODE_FOLLOW;
            bypass_runs++;
        end else begin
            beats[0] = drive_beat('0, '0, HOLD_STOP, m);
            n = 1;
            stop_passes++;
        end
        beats[n-1].last_of_run = 1'b1;
        for (int k = 0; k < n; k++)
            expected_drives.push_back(beats[k]);

        if (p.cmd != CMD_NONE)
            cur_cmd = p.cmd;
        if (cur_cmd != app_cmd) begin
            case (cur_cmd)
                CMD_FOLLOW:  robot_mode = MODE_FOLLOW;
                CMD_STOP:    robot_mode = MODE_STOP;
                CMD_FORWARD: reverse_on = 1'b0;
                CMD_REVERSE: reverse_on = 1'b1;
                default: ;
            endcase
            app_cmd = cur_cmd;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t: beat %0d %s: got %0d, want %0d", $realtime, beats_checked, what,
                 got, want);
    endtask

    // sender: present pending passes, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_drives(cur_pass);
                passes_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_passes.size() > 0) begin
                    cur_pass = pending_passes.pop_front();
                    s_valid              <= 1'b1;
                    s_sensor_left_outer  <= cur_pass.lo;
                    s_sensor_left_inner  <= cur_pass.li;
                    s_sensor_middle      <= cur_pass.mi;
                    s_sensor_right_inner <= cur_pass.ri;
                    s_sensor_right_outer <= cur_pass.ro;
                    s_echo_low_us        <= cur_pass.echo;
                    s_command_in         <= cur_pass.cmd;
                    send_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure, compare each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                seen_drive.left_forward  = m_left_forward;
                seen_drive.left_speed    = m_left_speed;
                seen_drive.right_forward = m_right_forward;
                seen_drive.right_speed   = m_right_speed;
                seen_drive.hold_ms       = m_hold_ms;
                seen_drive.mode_now      = m_mode_now;
                seen_drive.last_of_run   = m_last_of_run;
                if (expected_drives.size() == 0) begin
                    report_mismatch("beat with no pass pending, hold_ms", m_hold_ms, 0);
                end else begin
                    want_drive = expected_drives.pop_front();
                    if (seen_drive.left_forward !== want_drive.left_forward)
                        report_mismatch("left_forward", seen_drive.left_forward,
                                        want_drive.left_forward);
                    if (seen_drive.left_speed !== want_drive.left_speed)
                        report_mismatch("left_speed", seen_drive.left_speed,
                                        want_drive.left_speed);
                    if (seen_drive.right_forward !== want_drive.right_forward)
                        report_mismatch("right_forward", seen_drive.right_forward,
                                        want_drive.right_forward);
                    if (seen_drive.right_speed !== want_drive.right_speed)
                        report_mismatch("right_speed", seen_drive.right_speed,
                                        want_drive.right_speed);
                    if (seen_drive.hold_ms !== want_drive.hold_ms)
                        report_mismatch("hold_ms", seen_drive.hold_ms, want_drive.hold_ms);
                    if (seen_drive.mode_now !== want_drive.mode_now)
                        report_mismatch("mode_now", seen_drive.mode_now, want_drive.mode_now);
                    if (seen_drive.last_of_run !== want_drive.last_of_run)
                        report_mismatch("last_of_run", seen_drive.last_of_run,
                                        want_drive.last_of_run);
                end
                beats_checked++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                     expected_drives.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic add_pass(input logic [SENSOR_W-1:0] lo, input logic [SENSOR_W-1:0] li,
                            input logic [SENSOR_W-1:0] mi, input logic [SENSOR_W-1:0] ri,
                            input logic [SENSOR_W-1:0] ro, input logic [ECHO_W-1:0] echo,
                            input logic [CMD_W-1:0] cmd);
        sensor_pass_t p;
        p = '{lo: lo, li: li, mi: mi, ri: ri, ro: ro, echo: echo, cmd: cmd};
        pending_passes.push_back(p);
    endtask

    function automatic logic [SENSOR_W-1:0] lane_level(input logic on);
        if ($urandom_range(0, 9) == 0)
            return on ? line_thresh + 10'd1 : line_thresh;
        if (on && line_thresh >= 10'd1000)
            return SENSOR_W'($urandom_range(1001, 1023));
        if (on)
            return SENSOR_W'($urandom_range(line_thresh + 1, 1000));
        return SENSOR_W'($urandom_range(0, line_thresh));
    endfunction

    task automatic add_random(input int count);
        sensor_pass_t p;
        logic [4:0]   shape;
        int           r, d;
        repeat (count) begin
            if ($urandom_range(0, 99) < 25) begin
                p.lo = SENSOR_W'($urandom_range(0, 1000));
                p.li = SENSOR_W'($urandom_range(0, 1000));
                p.mi = SENSOR_W'($urandom_range(0, 1000));
                p.ri = SENSOR_W'($urandom_range(0, 1000));
                p.ro = SENSOR_W'($urandom_range(0, 1000));
            end else begin
                shape = 5'($urandom_range(0, 31));
                p.lo = lane_level(shape[4]);
                p.li = lane_level(shape[3]);
                p.mi = lane_level(shape[2]);
                p.ri = lane_level(shape[1]);
                p.ro = lane_level(shape[0]);
            end
            r = $urandom_range(0, 99);
            if (r < 30) begin
                p.echo = '0;
            end else if (r < 50 && prox_cm > min_cm + 1) begin
                d = $urandom_range(min_cm + 1, prox_cm - 1);
                p.echo = ECHO_W'(d * 50 + $urandom_range(0, 49));
            end else if (r < 97) begin
                p.echo = ECHO_W'($urandom_range(0, 30000));
            end else begin
                p.echo = '1;
            end
            r = $urandom_range(0, 99);
            if (r < 82)
                p.cmd = CMD_NONE;
            else if (r < 88)
                p.cmd = CMD_FOLLOW;
            else if (r < 91)
                p.cmd = CMD_FORWARD;
            else if (r < 94)
                p.cmd = CMD_REVERSE;
            else if (r < 96)
                p.cmd = CMD_STOP;
            else
                p.cmd = CMD_W'($urandom_range(0, 255));
            pending_passes.push_back(p);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_LINE_THRESHOLD: line_thresh = val[SENSOR_W-1:0];
            REG_CRUISE_LVL:     base_lvl    = val[SPEED_W-1:0];
            REG_PIVOT_LVL:      turn_lvl    = val[SPEED_W-1:0];
            REG_PROXIMITY_CM:   prox_cm     = val[SENSOR_W-1:0];
            REG_MIN_DIST_CM:    min_cm      = val[SENSOR_W-1:0];
            REG_CREEP_SPEED:    creep_lvl   = val[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int th, input int base, input int turn,
                                  input int prox, input int near, input int creep);
        write_reg(REG_LINE_THRESHOLD, CFG_DAT_W'(th));
        write_reg(REG_CRUISE_LVL, CFG_DAT_W'(base));
        write_reg(REG_PIVOT_LVL, CFG_DAT_W'(turn));
        write_reg(REG_PROXIMITY_CM, CFG_DAT_W'(prox));
        write_reg(REG_MIN_DIST_CM, CFG_DAT_W'(near));
        write_reg(REG_CREEP_SPEED, CFG_DAT_W'(creep));
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
        @(negedge aclk);
    endtask

    // wait until every pass is sent and every predicted beat has come back
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pending_passes.size() != 0 || s_valid || expected_drives.size() != 0);
    endtask

    initial begin
        line_thresh = RST_LINE_THRESHOLD;
        base_lvl    = RST_CRUISE_LVL;
        turn_lvl    = RST_PIVOT_LVL;
        prox_cm     = RST_PROXIMITY_CM;
        min_cm      = RST_MIN_DIST_CM;
        creep_lvl   = RST_CREEP_SPEED;
        robot_mode  = MODE_FOLLOW;
        last_dev    = DEV_NONE;
        reverse_on  = 1'b0;
        cur_cmd     = CMD_FOLLOW;
        app_cmd     = CMD_FOLLOW;
        left_dir    = 1'b0;
        right_dir   = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // steering chain at register defaults
        add_pass('0, '0, '0, '0, '0, '0, CMD_NONE);
        add_pass(LVL_OFF, LVL_ON, LVL_ON, LVL_OFF, LVL_OFF, '0, CMD_NONE);
        add_pass(LVL_OFF, LVL_OFF, LVL_ON, LVL_ON, LVL_OFF, '0, CMD_NONE);
        add_pass(LVL_OFF, LVL_ON, LVL_OFF, LVL_OFF, LVL_OFF, '0, CMD_NONE);
        add_pass(LVL_OFF, LVL_OFF, LVL_OFF, LVL_ON, LVL_OFF, '0, CMD_NONE);
        add_pass(LVL_ON, LVL_OFF, LVL_OFF, LVL_OFF, LVL_OFF, '0, CMD_NONE);
        add_pass('0, '0, '0, '0, '0, '0, CMD_NONE);
        // left side remembered wins over the right outer sensor
        add_pass(LVL_OFF, LVL_OFF, LVL_OFF, LVL_OFF, LVL_ON, '0, CMD_NONE);
        add_pass(LVL_OFF, LVL_ON, LVL_OFF, LVL_OFF, LVL_OFF, '0, CMD_NONE);
        add_pass(LVL_OFF, LVL_OFF, LVL_OFF, LVL_OFF, LVL_ON, '0, CMD_NONE);
        add_pass('0, '0, '0, '0, '0, '0, CMD_NONE);
        // readings equal to the threshold do not see the line
        add_pass(10'd750, 10'd750, 10'd750, 10'd750, 10'd751, '0, CMD_NONE);
        add_pass(10'd750, 10'd751, 10'd751, 10'd750, 10'd750, '0, CMD_NONE);
        // distance just inside, then the bypass, then both window edges
        add_pass(LVL_OFF, LVL_ON, LVL_ON, LVL_OFF, LVL_OFF, 15'd550, CMD_NONE);
        add_pass(LVL_OFF, LVL_ON, LVL_ON, LVL_OFF, LVL_OFF, 15'd1000, CMD_NONE);
        add_pass(LVL_OFF, LVL_ON, LVL_ON, LVL_OFF, LVL_OFF, 15'd549, CMD_NONE);
        add_pass(LVL_OFF, LVL_ON, LVL_ON, LVL_OFF, LVL_OFF, 15'd1500, CMD_NONE);
        // obstacle and stop command in one pass skips the bypass
        add_pass(LVL_OFF, LVL_ON, LVL_ON, LVL_OFF, LVL_OFF, 15'd1499, CMD_STOP);
        add_pass(LVL_ON, LVL_ON, LVL_ON, LVL_ON, LVL_ON, 15'd1000, CMD_NONE);
        add_pass(LVL_OFF, LVL_ON, LVL_ON, LVL_OFF, LVL_OFF, '0, CMD_REVERSE);
        add_pass(LVL_OFF, LVL_ON, LVL_ON, LVL_OFF, LVL_OFF, '0, CMD_FOLLOW);
        add_pass(LVL_OFF, LVL_ON, LVL_OFF, LVL_OFF, LVL_OFF, '0, CMD_NONE);
        add_pass(LVL_OFF, LVL_OFF, LVL_OFF, LVL_OFF, LVL_OFF, 15'd1000, CMD_NONE);
        add_pass(LVL_OFF, LVL_OFF, LVL_OFF, LVL_OFF, LVL_OFF, '0, CMD_FORWARD);
        add_pass('1, '1, '1, '1, '1, '1, CMD_W'(255));
        add_pass('0, '0, '0, '0, '0, '0, CMD_FOLLOW);
        add_random(40);
        wait_idle();

        apply_settings(0, 0, 0, 0, 0, 0);
        add_random(35);
        wait_idle();

        // widest obstacle window, no idling on either side
        no_idle = 1'b1;
        apply_settings(1000, 255, 255, 600, 0, 255);
        add_random(35);
        wait_idle();
        no_idle = 1'b0;

        apply_settings($urandom_range(300, 900), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(20, 80),
                       $urandom_range(0, 15), $urandom_range(0, 255));
        add_random(40);
        wait_idle();

        apply_settings($urandom_range(0, 1000), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 600),
                       $urandom_range(0, 600), $urandom_range(0, 255));
        add_random(40);
        wait_idle();

        repeat (20) @(posedge aclk);
        $display("covered %0d passes over %0d register settings, %0d drive beats checked",
                 passes_accepted, settings_used, beats_checked);
        $display("obstacle stops %0d, bypass runs %0d, stop-mode passes %0d",
                 obstacle_stops, bypass_runs, stop_passes);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
